// File: rtl/core/fwrl_pkg.sv
// Package with the types and constants shared by the rate limiter files.
`default_nettype none
package fwrl_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned WINDOW_W      = 16;
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_REQUEST_LIMIT  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SECONDS = 3'd4;

    localparam logic [DATA_W-1:0]   DEFAULT_LIMIT       = 32'd60;
    localparam logic [DATA_W-1:0]   COUNT_MAX           = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0]   RESET_REQUEST_LIMIT = 32'd0;
    localparam logic [WINDOW_W-1:0] RESET_WINDOW        = 16'd60;

    typedef struct packed {
        logic [DATA_W-1:0]   request_limit;
        logic [WINDOW_W-1:0] window_seconds;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] win_begin;
    } t_entry;

endpackage
`default_nettype wire

// File: rtl/core/fwrl_if.sv
// Request and response channel interfaces of the rate limiter.
`default_nettype none
interface fwrl_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] client_address;
    logic [31:0] now_seconds;

    modport source (output valid, output client_address, output now_seconds, input ready);
    modport sink (input valid, input client_address, input now_seconds, output ready);
endinterface

interface fwrl_rsp_if;
    logic valid;
    logic ready;
    logic allowed;
    logic tracked;
    logic new_entry;

    modport source (output valid, output allowed, output tracked, output new_entry, input ready);
    modport sink (input valid, input allowed, input tracked, input new_entry, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fwrl_cfg.sv
// APB configuration registers of the rate limiter.
`default_nettype none
module fwrl_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [fwrl_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [fwrl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [fwrl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output fwrl_pkg::t_cfg                           o_cfg
);

    fwrl_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_limit  <= fwrl_pkg::RESET_REQUEST_LIMIT;
            r_cfg.window_seconds <= fwrl_pkg::RESET_WINDOW;
        end else if (w_wr) begin
            case (paddr)
                fwrl_pkg::ADDR_REQUEST_LIMIT: begin
                    r_cfg.request_limit <= pwdata;
                end
                fwrl_pkg::ADDR_WINDOW_SECONDS: begin
                    r_cfg.window_seconds <= pwdata[fwrl_pkg::WINDOW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            fwrl_pkg::ADDR_REQUEST_LIMIT:  prdata = r_cfg.request_limit;
            fwrl_pkg::ADDR_WINDOW_SECONDS: prdata = {{(fwrl_pkg::APB_DATA_W -
                                                     fwrl_pkg::WINDOW_W){1'b0}},
                                                     r_cfg.window_seconds};
            default:                       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/fwrl_mem.sv
// Client table memory with one write port and one registered read port.
`default_nettype none
module fwrl_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned IDX_W = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [IDX_W-1:0]     i_waddr,
    input  wire fwrl_pkg::t_entry     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [IDX_W-1:0]     i_raddr,
    output fwrl_pkg::t_entry          o_rdata
);

    fwrl_pkg::t_entry r_mem [DEPTH];
    fwrl_pkg::t_entry r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/per_client_fixed_window_rate_limiter_unit.sv
// Per-client fixed-window rate limiter: each request runs a linear scan that reads one table
// entry per cycle from the single read port of the client table memory, followed by a window
// check and a write back for a known client (a new client is written at the end of the scan
// if the table has room) and the response load. One request is handled at a time, and a new
// request is taken while the previous response still waits in the output register. The table
// needs no clearing after reset, since only entries below the fill count are read.
`default_nettype none
module per_client_fixed_window_rate_limiter_unit #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    fwrl_req_if.sink                             i_req,
    fwrl_rsp_if.source                           o_rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fwrl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [fwrl_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [fwrl_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CALC,
        S_WRITE,
        S_OUT
    } t_state;

    fwrl_pkg::t_cfg   w_cfg;
    fwrl_pkg::t_entry w_rdata;
    fwrl_pkg::t_entry w_wdata;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic             w_re;
    logic             w_issue;
    logic             w_hit;
    logic [31:0]      w_limit;
    logic [31:0]      w_elapsed;

    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_used,      n_used;
    logic [CNT_W-1:0]  r_rd_idx,    n_rd_idx;
    logic              r_cmp_valid, n_cmp_valid;
    logic [IDX_W-1:0]  r_cmp_idx,   n_cmp_idx;
    logic [IDX_W-1:0]  r_hit_idx,   n_hit_idx;
    logic [31:0]       r_key,       n_key;
    logic [31:0]       r_now,       n_now;
    logic [31:0]       r_count,     n_count;
    logic [31:0]       r_start,     n_start;
    logic              r_res_allow, n_res_allow;
    logic              r_res_track, n_res_track;
    logic              r_res_new,   n_res_new;
    logic              r_out_valid, n_out_valid;
    logic              r_allowed,   n_allowed;
    logic              r_tracked,   n_tracked;
    logic              r_new_entry, n_new_entry;

    fwrl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fwrl_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.allowed   = r_allowed;
    assign o_rsp.tracked   = r_tracked;
    assign o_rsp.new_entry = r_new_entry;

    assign w_limit   = (w_cfg.request_limit == '0) ? fwrl_pkg::DEFAULT_LIMIT
                                                   : w_cfg.request_limit;
    assign w_issue   = (r_rd_idx < r_used);
    assign w_re      = (r_state == S_SEARCH) && w_issue;
    assign w_hit     = r_cmp_valid && (w_rdata.address == r_key);
    assign w_elapsed = r_now - r_start;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_rd_idx    = r_rd_idx;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_hit_idx   = r_hit_idx;
        n_key       = r_key;
        n_now       = r_now;
        n_count     = r_count;
        n_start     = r_start;
        n_res_allow = r_res_allow;
        n_res_track = r_res_track;
        n_res_new   = r_res_new;
        n_out_valid = r_out_valid;
        n_allowed   = r_allowed;
        n_tracked   = r_tracked;
        n_new_entry = r_new_entry;
        w_we        = 1'b0;
        w_waddr     = r_hit_idx;
        w_wdata     = '{address: r_key, count: r_count, win_begin: r_start};

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key       = i_req.client_address;
                    n_now       = i_req.now_seconds;
                    n_rd_idx    = '0;
                    n_cmp_valid = 1'b0;
                    n_state     = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_hit_idx = r_cmp_idx;
                    n_count   = w_rdata.count;
                    n_start   = w_rdata.win_begin;
                    n_state   = S_CALC;
                end else if (!w_issue && !r_cmp_valid) begin
                    if (r_used < FULL_COUNT) begin
                        w_we        = 1'b1;
                        w_waddr     = r_used[IDX_W-1:0];
                        w_wdata     = '{address: r_key, count: 32'd1, win_begin: r_now};
                        n_used      = r_used + CNT_W'(1);
                        n_res_track = 1'b1;
                        n_res_new   = 1'b1;
                    end else begin
                        n_res_track = 1'b0;
                        n_res_new   = 1'b0;
                    end
                    n_res_allow = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_cmp_valid = w_issue;
                    n_cmp_idx   = r_rd_idx[IDX_W-1:0];
                    if (w_issue) begin
                        n_rd_idx = r_rd_idx + CNT_W'(1);
                    end
                end
            end
            S_CALC: begin
                if (w_elapsed >= {16'd0, w_cfg.window_seconds}) begin
                    n_count = 32'd1;
                    n_start = r_now;
                end else if (r_count != fwrl_pkg::COUNT_MAX) begin
                    n_count = r_count + 32'd1;
                end
                n_state = S_WRITE;
            end
            S_WRITE: begin
                w_we        = 1'b1;
                n_res_allow = (r_count <= w_limit);
                n_res_track = 1'b1;
                n_res_new   = 1'b0;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_allowed   = r_res_allow;
                    n_tracked   = r_res_track;
                    n_new_entry = r_res_new;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_hit_idx   <= n_hit_idx;
        r_key       <= n_key;
        r_now       <= n_now;
        r_count     <= n_count;
        r_start     <= n_start;
        r_res_allow <= n_res_allow;
        r_res_track <= n_res_track;
        r_res_new   <= n_res_new;
        r_allowed   <= n_allowed;
        r_tracked   <= n_tracked;
        r_new_entry <= n_new_entry;
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_COUNT)
        else $error("Entry count exceeds table size.");

    a_new_implies_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.new_entry) |-> (o_rsp.tracked && o_rsp.allowed))
        else $error("New entry response is not tracked and allowed.");

    a_untracked_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.tracked) |-> (r_used == FULL_COUNT))
        else $error("Untracked response while the table has room.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_SEARCH))
        else $error("Accepted request did not start a table search.");

endmodule
`default_nettype wire

// File: tb/per_client_fixed_window_rate_limiter_unit_test.sv
// Self-checking testbench for the per-client fixed-window rate limiter unit.
`timescale 1ns / 100ps
module per_client_fixed_window_rate_limiter_unit_test;

    localparam int TABLE_ENTRIES = 256;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        logic allowed;
        logic tracked;
        logic new_entry;
    } t_decision;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [fwrl_pkg::APB_ADDR_W-1:0] paddr;
    logic [fwrl_pkg::APB_DATA_W-1:0] pwdata;
    logic [fwrl_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    fwrl_req_if request_bus();
    fwrl_rsp_if decision_bus();

    per_client_fixed_window_rate_limiter_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(request_bus),
        .o_rsp(decision_bus),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    fwrl_pkg::t_entry client_table[TABLE_ENTRIES];
    int clients_tracked;
    logic [fwrl_pkg::DATA_W-1:0] cur_limit;
    logic [fwrl_pkg::WINDOW_W-1:0] cur_window;

    t_decision pending_decisions[$];
    logic [31:0] known_clients[$];
    logic [31:0] wall_seconds;
    int sender_idle_pct;
    int receiver_idle_pct;
    int error_count;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_decision predict_decision(logic [31:0] address, logic [31:0] now);
        t_decision result;
        logic [fwrl_pkg::DATA_W-1:0] eff_limit;
        logic [fwrl_pkg::DATA_W-1:0] elapsed;
        int slot;
        eff_limit = (cur_limit != '0) ? cur_limit : fwrl_pkg::DEFAULT_LIMIT;
        slot = -1;
        for (int i = 0; i < clients_tracked; i++) begin
            if (slot < 0 && client_table[i].address == address) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            elapsed = now - client_table[slot].win_begin;
            if (elapsed >= {16'b0, cur_window}) begin
                client_table[slot].count = '0;
                client_table[slot].win_begin = now;
            end
            if (client_table[slot].count != fwrl_pkg::COUNT_MAX) begin
                client_table[slot].count = client_table[slot].count + 32'd1;
            end
            result.allowed = (client_table[slot].count <= eff_limit);
            result.tracked = 1'b1;
            result.new_entry = 1'b0;
        end else if (clients_tracked < TABLE_ENTRIES) begin
            client_table[clients_tracked].address = address;
            client_table[clients_tracked].count = 32'd1;
            client_table[clients_tracked].win_begin = now;
            clients_tracked++;
            result = '{allowed: 1'b1, tracked: 1'b1, new_entry: 1'b1};
        end else begin
            result = '{allowed: 1'b1, tracked: 1'b0, new_entry: 1'b0};
        end
        return result;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (actual !== expected) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, expected, actual);
            error_count++;
        end
    endtask

    always @(negedge i_clk) begin
        decision_bus.ready = ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin : check_decisions
        t_decision want;
        if (i_rst_n && decision_bus.valid && decision_bus.ready) begin
            if (pending_decisions.size() == 0) begin
                $display("%0t ns: response with no request outstanding, expected none, actual %b%b%b",
                         $time, decision_bus.allowed, decision_bus.tracked,
                         decision_bus.new_entry);
                error_count++;
            end else begin
                want = pending_decisions.pop_front();
                check_field("allowed", want.allowed, decision_bus.allowed);
                check_field("tracked", want.tracked, decision_bus.tracked);
                check_field("new_entry", want.new_entry, decision_bus.new_entry);
            end
        end
    end

    task automatic apb_transfer(input logic is_write,
                                input logic [fwrl_pkg::APB_ADDR_W-1:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = is_write;
        paddr = addr;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        request_bus.valid = 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [fwrl_pkg::DATA_W-1:0] limit,
                              input logic [fwrl_pkg::WINDOW_W-1:0] window);
        logic [31:0] rdata;
        wait_idle();
        apb_transfer(1'b1, fwrl_pkg::ADDR_REQUEST_LIMIT, limit, rdata);
        apb_transfer(1'b1, fwrl_pkg::ADDR_WINDOW_SECONDS, {16'b0, window}, rdata);
        apb_transfer(1'b0, fwrl_pkg::ADDR_REQUEST_LIMIT, '0, rdata);
        check_field("request_limit readback", limit, rdata);
        apb_transfer(1'b0, fwrl_pkg::ADDR_WINDOW_SECONDS, '0, rdata);
        check_field("window_seconds readback", {16'b0, window}, rdata);
        cur_limit = limit;
        cur_window = window;
    endtask

    task automatic send_request(input logic [31:0] address, input logic [31:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            request_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        request_bus.valid = 1'b1;
        request_bus.client_address = address;
        request_bus.now_seconds = now;
        do @(posedge i_clk); while (!request_bus.ready);
        pending_decisions.push_back(predict_decision(address, now));
    endtask

    function automatic logic [31:0] next_timestamp();
        int pick;
        pick = $urandom_range(999);
        if (pick < 700) begin
        end else if (pick < 985) begin
            wall_seconds = wall_seconds + $urandom_range(1, 3);
        end else if (pick < 995) begin
            wall_seconds = wall_seconds + $urandom_range(1, 70000);
        end else begin
            wall_seconds = $urandom;
        end
        return wall_seconds;
    endfunction

    task automatic test_register_reset_values();
        logic [31:0] rdata;
        apb_transfer(1'b0, fwrl_pkg::ADDR_REQUEST_LIMIT, '0, rdata);
        check_field("request_limit after reset", fwrl_pkg::RESET_REQUEST_LIMIT, rdata);
        apb_transfer(1'b0, fwrl_pkg::ADDR_WINDOW_SECONDS, '0, rdata);
        check_field("window_seconds after reset", {16'b0, fwrl_pkg::RESET_WINDOW}, rdata);
    endtask

    task automatic test_new_and_returning_clients();
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0003);
        send_request(32'h0000_0000, 32'd59);
        send_request(32'h0000_0000, 32'd60);
        send_request(32'h8000_0001, 32'h7FFF_FFFF);
    endtask

    task automatic test_limit_exhaustion();
        set_limits(32'd1, 16'd60);
        send_request(32'h0000_0000, 32'd60);
        send_request(32'h0000_0000, 32'd119);
        send_request(32'h0000_0000, 32'd120);
        send_request(32'h0000_0000, 32'd120);
    endtask

    task automatic test_zero_window();
        set_limits(32'd1, 16'd0);
        repeat (3) send_request(32'h0000_0000, 32'd120);
    endtask

    task automatic test_extreme_settings();
        set_limits(32'hFFFF_FFFF, 16'hFFFF);
        send_request(32'hFFFF_FFFF, 32'd65533);
        send_request(32'hFFFF_FFFF, 32'd65534);
        send_request(32'h8000_0001, 32'h7FFF_FFFF);
        send_request(32'h0000_0000, 32'h0000_0000);
        set_limits(32'd1, 16'd1);
        send_request(32'h8000_0001, 32'h8000_0000);
        send_request(32'h8000_0001, 32'h8000_0000);
        send_request(32'h8000_0001, 32'h8000_0001);
    endtask

    task automatic test_random_traffic();
        logic [fwrl_pkg::DATA_W-1:0] limit;
        logic [fwrl_pkg::WINDOW_W-1:0] window;
        logic [31:0] address;
        int sent;
        int run_len;
        wall_seconds = $urandom;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin limit = 32'd0;         window = 16'd60;    end
                1: begin limit = 32'd2;         window = 16'd30;    end
                2: begin limit = 32'd1;         window = 16'd1;     end
                3: begin limit = 32'd0;         window = 16'hFFFF;  end
                4: begin limit = 32'd5;         window = 16'd300;   end
                default: begin limit = 32'hFFFF_FFFF; window = 16'hFFFF; end
            endcase
            set_limits(limit, window);
            sender_idle_pct = (phase < 2) ? 38 : (phase < 4) ? 63 : 0;
            receiver_idle_pct = (phase < 2) ? 63 : (phase < 4) ? 38 : 0;
            sent = 0;
            while (sent < RANDOM_REQUESTS / RANDOM_PHASES) begin
                if ($urandom_range(99) < 30) begin
                    run_len = $urandom_range(1, 16);
                    repeat (run_len) begin
                        address = $urandom;
                        known_clients.push_back(address);
                        send_request(address, next_timestamp());
                        sent++;
                    end
                end else begin
                    if (known_clients.size() == 0 || $urandom_range(9) == 0) begin
                        address = $urandom;
                        known_clients.push_back(address);
                    end else begin
                        address = known_clients[$urandom_range(known_clients.size() - 1)];
                    end
                    run_len = ($urandom_range(99) < 8) ? $urandom_range(61, 70)
                                                       : $urandom_range(1, 12);
                    repeat (run_len) begin
                        send_request(address, next_timestamp());
                        sent++;
                    end
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        request_bus.valid = 1'b0;
        request_bus.client_address = '0;
        request_bus.now_seconds = '0;
        sender_idle_pct = 38;
        receiver_idle_pct = 63;
        error_count = 0;
        clients_tracked = 0;
        cur_limit = fwrl_pkg::RESET_REQUEST_LIMIT;
        cur_window = fwrl_pkg::RESET_WINDOW;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_reset_values();
        test_new_and_returning_clients();
        test_limit_exhaustion();
        test_zero_window();
        test_extreme_settings();
        test_random_traffic();

        wait_idle();
        repeat (TABLE_ENTRIES + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/fwrl_pkg.sv
rtl/core/fwrl_if.sv
rtl/core/fwrl_cfg.sv
rtl/core/fwrl_mem.sv
rtl/core/per_client_fixed_window_rate_limiter_unit.sv
tb/per_client_fixed_window_rate_limiter_unit_test.sv
